// ===== sv/chm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the chained hash map.
// Used by chm_free_stack and chained_hash_map_top; depends on nothing.
package chm_pkg;

  localparam int BUCKETS = 16;
  localparam int ENTRIES = 64;
  localparam int DATA_W = 32;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PTR_W = IDX_W + 1;
  localparam int NODE_W = 2 * DATA_W + PTR_W;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic             pop;
    logic [IDX_W-1:0] pop_addr;
    logic             push;
    logic [IDX_W-1:0] push_addr;
    logic [IDX_W-1:0] push_node;
  } fs_req_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [DATA_W-1:0] key_bits);
    logic [DATA_W-1:0] mag;
    mag = key_bits[DATA_W-1] ? (DATA_W'(0) - key_bits) : key_bits;
    return BKT_W'(mag % BUCKETS);
  endfunction

endpackage

// ===== sv/chm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/chm_free_stack.sv =====
`timescale 1ns / 1ps
// Free node stack: a RAM plus one valid bit per slot, an unwritten slot reads as its index.
// Depends on chm_pkg and chm_ram.
module chm_free_stack (
  input  logic                    clk,
  input  logic                    rst,
  input  chm_pkg::fs_req_t        req,
  output logic [chm_pkg::IDX_W-1:0] fresh
);

  logic [chm_pkg::ENTRIES-1:0] valid;
  logic                        rd_valid;
  logic [chm_pkg::IDX_W-1:0]   rd_addr;
  logic [chm_pkg::IDX_W-1:0]   rd_data;

  chm_ram #(.WIDTH(chm_pkg::IDX_W), .DEPTH(chm_pkg::ENTRIES)) u_ram (
    .clk   (clk),
    .we    (req.push),
    .waddr (req.push_addr),
    .wdata (req.push_node),
    .re    (req.pop),
    .raddr (req.pop_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
      rd_addr <= '0;
    end else begin
      if (req.push) begin
        valid[req.push_addr] <= 1'b1;
      end
      if (req.pop) begin
        rd_valid <= valid[req.pop_addr];
        rd_addr <= req.pop_addr;
      end
    end
  end

  assign fresh = rd_valid ? rd_data : rd_addr;

endmodule

// ===== sv/chained_hash_map_top.sv =====
`timescale 1ns / 1ps
// Chained hash map: buckets in flops, nodes in one RAM, free nodes on a RAM stack.
// The chain walk reads one node RAM word per cycle, and a new node linked at a chain
// tail takes an extra link step; an unused op code finishes without a walk. busy stays
// high until the done strobe, so no new transaction is taken before then. Synchronous
// reset empties every bucket and refills the free stack at once.
module chained_hash_map_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] read_value,
  output logic               pool_full,
  output logic [6:0]         entry_total
);

  typedef enum logic [2:0] {S_IDLE, S_START, S_CHECK, S_HIT, S_MISS, S_LINK} state_t;

  state_t                           state;
  logic [1:0]                       op_q;
  logic [chm_pkg::DATA_W-1:0]       key_q;
  logic [chm_pkg::DATA_W-1:0]       val_q;
  logic [chm_pkg::BKT_W-1:0]        bkt;
  logic [chm_pkg::PTR_W-1:0]        heads [chm_pkg::BUCKETS];
  logic [chm_pkg::PTR_W-1:0]        cur;
  logic [chm_pkg::PTR_W-1:0]        pred;
  logic [chm_pkg::PTR_W-1:0]        steps;
  logic [chm_pkg::NODE_W-1:0]       pred_word;
  logic [chm_pkg::NODE_W-1:0]       cur_word;
  logic [chm_pkg::PTR_W-1:0]        count;

  logic                             node_we;
  logic [chm_pkg::IDX_W-1:0]        node_waddr;
  logic [chm_pkg::NODE_W-1:0]       node_wdata;
  logic                             node_re;
  logic [chm_pkg::IDX_W-1:0]        node_raddr;
  logic [chm_pkg::NODE_W-1:0]       node_rdata;
  chm_pkg::fs_req_t                 fs_req;
  logic [chm_pkg::IDX_W-1:0]        fresh;

  logic [chm_pkg::DATA_W-1:0]       rd_key;
  logic [chm_pkg::PTR_W-1:0]        rd_link;
  logic [chm_pkg::PTR_W-1:0]        cur_link;
  logic [chm_pkg::PTR_W-1:0]        steps_next;

  assign rd_key = node_rdata[chm_pkg::NODE_W-1 -: chm_pkg::DATA_W];
  assign rd_link = node_rdata[chm_pkg::PTR_W-1:0];
  assign cur_link = cur_word[chm_pkg::PTR_W-1:0];
  assign steps_next = steps + chm_pkg::PTR_W'(1);

  chm_ram #(.WIDTH(chm_pkg::NODE_W), .DEPTH(chm_pkg::ENTRIES)) u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  chm_free_stack u_free (
    .clk   (clk),
    .rst   (rst),
    .req   (fs_req),
    .fresh (fresh)
  );

  always_comb begin
    node_we = 1'b0;
    node_waddr = cur[chm_pkg::IDX_W-1:0];
    node_wdata = {key_q, val_q, cur_link};
    node_re = 1'b0;
    node_raddr = heads[bkt][chm_pkg::IDX_W-1:0];
    fs_req = '0;
    fs_req.pop_addr = chm_pkg::IDX_W'(chm_pkg::ENTRIES - 1) - chm_pkg::IDX_W'(count);
    fs_req.push_addr = chm_pkg::IDX_W'(chm_pkg::ENTRIES) - chm_pkg::IDX_W'(count);
    fs_req.push_node = cur[chm_pkg::IDX_W-1:0];
    unique case (state)
      S_START: begin
        fs_req.pop = 1'b1;
        node_re = (heads[bkt] != chm_pkg::NIL);
      end
      S_CHECK: begin
        node_raddr = rd_link[chm_pkg::IDX_W-1:0];
        node_re = (rd_key != key_q) && (rd_link != chm_pkg::NIL)
                  && (steps_next != chm_pkg::PTR_W'(chm_pkg::ENTRIES));
      end
      S_HIT: begin
        if (op_q == chm_pkg::OP_INSERT) begin
          node_we = 1'b1;
        end else if (op_q == chm_pkg::OP_REMOVE && count != '0) begin
          fs_req.push = 1'b1;
          if (pred != chm_pkg::NIL) begin
            node_we = 1'b1;
            node_waddr = pred[chm_pkg::IDX_W-1:0];
            node_wdata = {pred_word[chm_pkg::NODE_W-1:chm_pkg::PTR_W], cur_link};
          end
        end
      end
      S_MISS: begin
        if (op_q == chm_pkg::OP_INSERT && count < chm_pkg::PTR_W'(chm_pkg::ENTRIES)) begin
          node_we = 1'b1;
          node_waddr = fresh;
          node_wdata = {key_q, val_q, chm_pkg::NIL};
        end
      end
      S_LINK: begin
        node_we = 1'b1;
        node_waddr = pred[chm_pkg::IDX_W-1:0];
        node_wdata = {pred_word[chm_pkg::NODE_W-1:chm_pkg::PTR_W], 1'b0, fresh};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
      for (int i = 0; i < chm_pkg::BUCKETS; i++) begin
        heads[i] <= chm_pkg::NIL;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q <= op;
            key_q <= key;
            val_q <= value;
            bkt <= chm_pkg::bucket_of(key);
            busy <= 1'b1;
            state <= S_START;
          end
        end
        S_START: begin
          cur <= heads[bkt];
          pred <= chm_pkg::NIL;
          steps <= '0;
          if (op_q != chm_pkg::OP_INSERT && op_q != chm_pkg::OP_LOOKUP
              && op_q != chm_pkg::OP_REMOVE) begin
            hit <= 1'b0;
            read_value <= '0;
            pool_full <= 1'b0;
            done <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else if (heads[bkt] == chm_pkg::NIL) begin
            state <= S_MISS;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_key == key_q) begin
            cur_word <= node_rdata;
            state <= S_HIT;
          end else begin
            pred <= cur;
            pred_word <= node_rdata;
            cur <= rd_link;
            steps <= steps_next;
            if (rd_link == chm_pkg::NIL || steps_next == chm_pkg::PTR_W'(chm_pkg::ENTRIES)) begin
              state <= S_MISS;
            end
          end
        end
        S_HIT: begin
          hit <= 1'b1;
          pool_full <= 1'b0;
          read_value <= '0;
          if (op_q == chm_pkg::OP_LOOKUP) begin
            read_value <= cur_word[chm_pkg::NODE_W-chm_pkg::DATA_W-1:chm_pkg::PTR_W];
          end else if (op_q == chm_pkg::OP_REMOVE) begin
            if (count != '0) begin
              count <= count - chm_pkg::PTR_W'(1);
              if (pred == chm_pkg::NIL) begin
                heads[bkt] <= cur_link;
              end
            end else begin
              hit <= 1'b0;
            end
          end
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        S_MISS: begin
          hit <= 1'b0;
          pool_full <= 1'b0;
          read_value <= '0;
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
          if (op_q == chm_pkg::OP_LOOKUP) begin
            read_value <= chm_pkg::MISS_VALUE;
          end else if (op_q == chm_pkg::OP_INSERT) begin
            if (count >= chm_pkg::PTR_W'(chm_pkg::ENTRIES)) begin
              pool_full <= 1'b1;
            end else if (pred == chm_pkg::NIL) begin
              heads[bkt] <= {1'b0, fresh};
              count <= count + chm_pkg::PTR_W'(1);
            end else begin
              done <= 1'b0;
              busy <= 1'b1;
              state <= S_LINK;
            end
          end
        end
        S_LINK: begin
          count <= count + chm_pkg::PTR_W'(1);
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign entry_total = count;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe while still busy.");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= chm_pkg::PTR_W'(chm_pkg::ENTRIES))
    else $error("Entry count exceeds the node pool.");
  a_full_nohit: assert property (@(posedge clk) disable iff (rst) done |-> !(pool_full && hit))
    else $error("Pool full reported together with a hit.");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("Accepted transaction did not raise busy.");

endmodule
